[src/cat_pkg.sv]
// ---------------------------------------------------------------------------
// cat_pkg: shared types and constants for the closest approach time block
// Field widths, per-stage payload structs and the register reset value.
// ---------------------------------------------------------------------------
package cat_pkg;

   localparam int CRD_W       = 24;   // position and velocity components
   localparam int RAD_W       = 23;   // combined radius
   localparam int TIME_W      = 24;   // Q8.16 seconds
   localparam int PROD_W      = 48;   // one 24 x 24 product
   localparam int HALF_W      = 24;   // partial product operand
   localparam int WIDE_W      = 96;   // b^2 and A*|C|
   localparam int D_W         = 98;   // discriminant
   localparam int ROOT_W      = 49;   // floor(sqrt(D))
   localparam int REM_W       = 52;   // square root remainder
   localparam int SQRT_STEPS  = D_W / 2;
   localparam int DIV_STEPS   = TIME_W;
   localparam int FRAC_W      = 16;
   localparam int SAT_SHIFT   = DIV_STEPS - FRAC_W;

   localparam logic [TIME_W-1:0] HORIZON_RESET = TIME_W'(196608);
   localparam logic [TIME_W-1:0] TIME_SAT      = '1;

   typedef struct packed {
      logic signed [CRD_W-1:0] rel_pos_x;
      logic signed [CRD_W-1:0] rel_pos_y;
      logic signed [CRD_W-1:0] rel_pos_z;
      logic signed [CRD_W-1:0] rel_vel_x;
      logic signed [CRD_W-1:0] rel_vel_y;
      logic signed [CRD_W-1:0] rel_vel_z;
      logic [RAD_W-1:0]        sum_radius;
   } req_type;

   typedef struct packed {
      logic [TIME_W-1:0] approach_time;
      logic              no_relative_motion;
   } rsp_type;

   typedef struct packed {
      logic [TIME_W-1:0] time_horizon;
   } csr_type;

   // products of the first stage
   typedef struct packed {
      logic signed [PROD_W-1:0] pxx, pyy, pzz;
      logic signed [PROD_W-1:0] vxx, vyy, vzz;
      logic signed [PROD_W-1:0] vpx, vpy, vpz;
      logic [2*RAD_W-1:0]       rr;
   } prod_type;

   typedef struct packed {
      logic [PROD_W-1:0] a;
      logic [PROD_W-1:0] nb;
      logic [PROD_W-1:0] magc;
      logic              cneg;
      logic              zero;
   } coef_type;

   typedef struct packed {
      logic [PROD_W-1:0] bb00, bb01, bb11;
      logic [PROD_W-1:0] ac00, ac01, ac10, ac11;
      logic [PROD_W-1:0] a;
      logic [PROD_W-1:0] nb;
      logic              cneg;
      logic              zero;
   } part_type;

   typedef struct packed {
      logic [WIDE_W-1:0] bb;
      logic [WIDE_W-1:0] ac;
      logic [PROD_W-1:0] a;
      logic [PROD_W-1:0] nb;
      logic              cneg;
      logic              zero;
   } wide_type;

   typedef struct packed {
      logic [D_W-1:0]    d;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
      logic [PROD_W-1:0] a;
      logic [PROD_W-1:0] nb;
      logic              zero;
   } sqrt_type;

   typedef struct packed {
      logic [PROD_W-1:0] n;
      logic [PROD_W-1:0] a;
      logic              zero;
   } diff_type;

   typedef struct packed {
      logic [PROD_W-1:0] r;
      logic [TIME_W-1:0] lo;
      logic [TIME_W-1:0] q;
      logic [PROD_W-1:0] a;
      logic              sat;
      logic              zero;
   } div_type;

endpackage

[src/cat_chan_if.sv]
// ---------------------------------------------------------------------------
// cat_chan_if: valid/ready channel
// Carries one payload beat per handshake.
// ---------------------------------------------------------------------------
interface cat_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[src/cat_front.sv]
// ---------------------------------------------------------------------------
// cat_front: products and discriminant
// Five registered stages from the input beat to the discriminant D.
// ---------------------------------------------------------------------------
module cat_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  cat_pkg::req_type in_data,
   output logic             in_ready,
   output logic             out_valid,
   output cat_pkg::sqrt_type out_data,
   input  logic             out_ready
);
   import cat_pkg::*;

   localparam int NSTG = 5;

   logic [NSTG-1:0] valid_ff, valid_in, rdy_up, rdy_dn, vin, load;

   prod_type s1_ff, s1_in;
   coef_type s2_ff, s2_in;
   part_type s3_ff, s3_in;
   wide_type s4_ff, s4_in;
   sqrt_type s5_ff, s5_in;

   logic [PROD_W-1:0]        a_sum, pp_sum;
   logic signed [PROD_W+1:0] vp_sum, c_val;

   // a stage takes a beat when it is empty or its beat moves on
   // walked from the output end so each ready sees its downstream neighbour
   always_comb begin
      for (int k = NSTG-1; k >= 0; k--) begin
         rdy_dn[k]   = (k == NSTG-1) ? out_ready : rdy_up[(k+1) % NSTG];
         rdy_up[k]   = ~valid_ff[k] | rdy_dn[k];
         vin[k]      = (k == 0) ? in_valid : valid_ff[(k+NSTG-1) % NSTG];
         load[k]     = rdy_up[k] & vin[k];
         valid_in[k] = rdy_up[k] ? vin[k] : valid_ff[k];
      end
   end

   always_comb begin
      s1_in.pxx = in_data.rel_pos_x * in_data.rel_pos_x;
      s1_in.pyy = in_data.rel_pos_y * in_data.rel_pos_y;
      s1_in.pzz = in_data.rel_pos_z * in_data.rel_pos_z;
      s1_in.vxx = in_data.rel_vel_x * in_data.rel_vel_x;
      s1_in.vyy = in_data.rel_vel_y * in_data.rel_vel_y;
      s1_in.vzz = in_data.rel_vel_z * in_data.rel_vel_z;
      s1_in.vpx = in_data.rel_vel_x * in_data.rel_pos_x;
      s1_in.vpy = in_data.rel_vel_y * in_data.rel_pos_y;
      s1_in.vpz = in_data.rel_vel_z * in_data.rel_pos_z;
      s1_in.rr  = in_data.sum_radius * in_data.sum_radius;
   end

   always_comb begin
      a_sum  = $unsigned(s1_ff.vxx) + $unsigned(s1_ff.vyy) + $unsigned(s1_ff.vzz);
      pp_sum = $unsigned(s1_ff.pxx) + $unsigned(s1_ff.pyy) + $unsigned(s1_ff.pzz);
      vp_sum = (PROD_W+2)'(s1_ff.vpx) + (PROD_W+2)'(s1_ff.vpy) + (PROD_W+2)'(s1_ff.vpz);
      c_val  = $signed({2'b00, pp_sum}) - $signed({4'b0000, s1_ff.rr});
      s2_in.a    = a_sum;
      s2_in.nb   = vp_sum[PROD_W+1] ? PROD_W'(-vp_sum) : '0;
      s2_in.cneg = c_val[PROD_W+1];
      s2_in.magc = c_val[PROD_W+1] ? PROD_W'(-c_val) : PROD_W'(c_val);
      s2_in.zero = (a_sum == '0);
   end

   // 48 x 48 products cut into 24 x 24 pieces
   always_comb begin
      s3_in.bb00 = s2_ff.nb[HALF_W-1:0] * s2_ff.nb[HALF_W-1:0];
      s3_in.bb01 = s2_ff.nb[HALF_W-1:0] * s2_ff.nb[PROD_W-1:HALF_W];
      s3_in.bb11 = s2_ff.nb[PROD_W-1:HALF_W] * s2_ff.nb[PROD_W-1:HALF_W];
      s3_in.ac00 = s2_ff.a[HALF_W-1:0] * s2_ff.magc[HALF_W-1:0];
      s3_in.ac01 = s2_ff.a[HALF_W-1:0] * s2_ff.magc[PROD_W-1:HALF_W];
      s3_in.ac10 = s2_ff.a[PROD_W-1:HALF_W] * s2_ff.magc[HALF_W-1:0];
      s3_in.ac11 = s2_ff.a[PROD_W-1:HALF_W] * s2_ff.magc[PROD_W-1:HALF_W];
      s3_in.a    = s2_ff.a;
      s3_in.nb   = s2_ff.nb;
      s3_in.cneg = s2_ff.cneg;
      s3_in.zero = s2_ff.zero;
   end

   always_comb begin
      s4_in.bb = {s3_ff.bb11, s3_ff.bb00}
               + (WIDE_W'(s3_ff.bb01) << (HALF_W + 1));
      s4_in.ac = {s3_ff.ac11, s3_ff.ac00}
               + (WIDE_W'(s3_ff.ac01) << HALF_W)
               + (WIDE_W'(s3_ff.ac10) << HALF_W);
      s4_in.a    = s3_ff.a;
      s4_in.nb   = s3_ff.nb;
      s4_in.cneg = s3_ff.cneg;
      s4_in.zero = s3_ff.zero;
   end

   // D = b^2 - A*C, floored at zero
   always_comb begin
      if (s4_ff.cneg) begin
         s5_in.d = D_W'(s4_ff.bb) + D_W'(s4_ff.ac);
      end else if (s4_ff.ac <= s4_ff.bb) begin
         s5_in.d = D_W'(s4_ff.bb - s4_ff.ac);
      end else begin
         s5_in.d = '0;
      end
      s5_in.rem  = '0;
      s5_in.root = '0;
      s5_in.a    = s4_ff.a;
      s5_in.nb   = s4_ff.nb;
      s5_in.zero = s4_ff.zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load[0]) s1_ff <= s1_in;
      if (load[1]) s2_ff <= s2_in;
      if (load[2]) s3_ff <= s3_in;
      if (load[3]) s4_ff <= s4_in;
      if (load[4]) s5_ff <= s5_in;
   end

   assign in_ready  = rdy_up[0];
   assign out_valid = valid_ff[NSTG-1];
   assign out_data  = s5_ff;

endmodule

[src/cat_sqrt_cell.sv]
// ---------------------------------------------------------------------------
// cat_sqrt_cell: one digit of the integer square root
// Brings down two bits of D and settles one bit of the root.
// ---------------------------------------------------------------------------
module cat_sqrt_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  cat_pkg::sqrt_type in_data,
   output logic              in_ready,
   output logic              out_valid,
   output cat_pkg::sqrt_type out_data,
   input  logic              out_ready
);
   import cat_pkg::*;

   logic     valid_ff, valid_in;
   sqrt_type data_ff, data_in;
   logic [REM_W-1:0] rem_t, trial;
   logic             ge;

   always_comb begin
      rem_t = {in_data.rem[REM_W-3:0], in_data.d[D_W-1 -: 2]};
      trial = REM_W'({in_data.root, 2'b01});
      ge    = (rem_t >= trial);
      data_in      = in_data;
      data_in.d    = in_data.d << 2;
      data_in.rem  = ge ? rem_t - trial : rem_t;
      data_in.root = {in_data.root[ROOT_W-2:0], ge};
   end

   assign in_ready = ~valid_ff | out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready & in_valid) data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[src/cat_div_cell.sv]
// ---------------------------------------------------------------------------
// cat_div_cell: one step of restoring division
// Shifts in one dividend bit and settles one quotient bit.
// ---------------------------------------------------------------------------
module cat_div_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  cat_pkg::div_type in_data,
   output logic             in_ready,
   output logic             out_valid,
   output cat_pkg::div_type out_data,
   input  logic             out_ready
);
   import cat_pkg::*;

   logic    valid_ff, valid_in;
   div_type data_ff, data_in;
   logic [PROD_W:0] rt, dv;
   logic            ge;

   always_comb begin
      rt = {in_data.r, in_data.lo[TIME_W-1]};
      dv = {1'b0, in_data.a};
      ge = (rt >= dv);
      data_in    = in_data;
      data_in.r  = ge ? PROD_W'(rt - dv) : rt[PROD_W-1:0];
      data_in.lo = in_data.lo << 1;
      data_in.q  = {in_data.q[TIME_W-2:0], ge};
   end

   assign in_ready = ~valid_ff | out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready & in_valid) data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[src/closest_approach_time.sv]
// ---------------------------------------------------------------------------
// closest_approach_time: time of first contact or closest approach
// One agent pair in, one clamped Q8.16 time out.
// ---------------------------------------------------------------------------
// Channels: req_chan takes one agent pair per beat (relative position,
// relative velocity, combined radius). rsp_chan gives one beat per pair,
// in order: approach_time and no_relative_motion. csr_chan writes
// time_horizon, the upper clamp on the result; it is always ready. The user
// must write it only while no pair is in flight; the block does not enforce it.
// Path: an accepted req beat passes through five stages of products and
// discriminant, 49 square root cells, two set-up stages, 24 division cells
// and the output register before its rsp beat leaves.
// Throughput: one pair per cycle while rsp_chan is ready; every cell is a stage.
// Stall: when rsp_chan.ready is low, beats queue up in the empty cells
// and req_chan.ready drops only once every cell is occupied.
// Reset: all cells empty, time_horizon back to 3 s (196608).
// ---------------------------------------------------------------------------
module closest_approach_time (
   input logic clock,
   input logic reset,
   cat_chan_if.sink   req_chan,
   cat_chan_if.source rsp_chan,
   cat_chan_if.sink   csr_chan
);
   import cat_pkg::*;

   logic [TIME_W-1:0] horizon_ff;

   logic     sq_valid [0:SQRT_STEPS];
   logic     sq_ready [0:SQRT_STEPS];
   sqrt_type sq_data  [0:SQRT_STEPS];

   logic    dv_valid [0:DIV_STEPS];
   logic    dv_ready [0:DIV_STEPS];
   div_type dv_data  [0:DIV_STEPS];

   logic     nd_valid_ff, nd_valid_in, nd_rdy;
   diff_type nd_ff, nd_in;
   logic     pr_rdy, pr_valid_in, pr_valid_ff;
   div_type  pr_ff, pr_in;
   logic     out_rdy, out_valid_in, out_valid_ff;
   rsp_type  out_ff, out_in;
   logic [TIME_W-1:0] t_raw;

   // configuration
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         horizon_ff <= HORIZON_RESET;
      end else if (csr_chan.valid) begin
         horizon_ff <= csr_chan.payload.time_horizon;
      end
   end

   cat_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_data   (req_chan.payload),
      .in_ready  (req_chan.ready),
      .out_valid (sq_valid[0]),
      .out_data  (sq_data[0]),
      .out_ready (sq_ready[0])
   );

   for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
      cat_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (sq_valid[i]),
         .in_data   (sq_data[i]),
         .in_ready  (sq_ready[i]),
         .out_valid (sq_valid[i+1]),
         .out_data  (sq_data[i+1]),
         .out_ready (sq_ready[i+1])
      );
   end

   // numerator: -b - floor(sqrt(D)), zero when not approaching
   assign nd_rdy        = ~nd_valid_ff | pr_rdy;
   assign sq_ready[SQRT_STEPS] = nd_rdy;
   assign nd_valid_in   = nd_rdy ? sq_valid[SQRT_STEPS] : nd_valid_ff;

   always_comb begin
      nd_in.n    = (sq_data[SQRT_STEPS].root < ROOT_W'(sq_data[SQRT_STEPS].nb))
                 ? PROD_W'(ROOT_W'(sq_data[SQRT_STEPS].nb) - sq_data[SQRT_STEPS].root)
                 : '0;
      nd_in.a    = sq_data[SQRT_STEPS].a;
      nd_in.zero = sq_data[SQRT_STEPS].zero;
   end

   // division set-up: saturate at 256 s, else start with the top of n
   assign pr_rdy      = ~pr_valid_ff | dv_ready[0];
   assign pr_valid_in = pr_rdy ? nd_valid_ff : pr_valid_ff;

   always_comb begin
      pr_in.sat  = ({SAT_SHIFT'(0), nd_ff.n} >= {nd_ff.a, SAT_SHIFT'(0)});
      pr_in.r    = nd_ff.n >> SAT_SHIFT;
      pr_in.lo   = {nd_ff.n[SAT_SHIFT-1:0], FRAC_W'(0)};
      pr_in.q    = '0;
      pr_in.a    = nd_ff.a;
      pr_in.zero = nd_ff.zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nd_valid_ff  <= 1'b0;
         pr_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         nd_valid_ff  <= nd_valid_in;
         pr_valid_ff  <= pr_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (nd_rdy & sq_valid[SQRT_STEPS]) nd_ff <= nd_in;
      if (pr_rdy & nd_valid_ff) pr_ff <= pr_in;
      if (out_rdy & dv_valid[DIV_STEPS]) out_ff <= out_in;
   end

   assign dv_valid[0] = pr_valid_ff;
   assign dv_data[0]  = pr_ff;

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      cat_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (dv_valid[j]),
         .in_data   (dv_data[j]),
         .in_ready  (dv_ready[j]),
         .out_valid (dv_valid[j+1]),
         .out_data  (dv_data[j+1]),
         .out_ready (dv_ready[j+1])
      );
   end

   // result beat with clamp to the horizon
   assign out_rdy              = ~out_valid_ff | rsp_chan.ready;
   assign dv_ready[DIV_STEPS]  = out_rdy;
   assign out_valid_in         = out_rdy ? dv_valid[DIV_STEPS] : out_valid_ff;

   always_comb begin
      priority if (dv_data[DIV_STEPS].zero) begin
         t_raw = '0;
      end else if (dv_data[DIV_STEPS].sat) begin
         t_raw = TIME_SAT;
      end else begin
         t_raw = dv_data[DIV_STEPS].q;
      end
      out_in.approach_time      = (t_raw > horizon_ff) ? horizon_ff : t_raw;
      out_in.no_relative_motion = dv_data[DIV_STEPS].zero;
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_ff;

`ifndef SYNTHESIS
   a_still_no_time : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.payload.no_relative_motion
         |-> rsp_chan.payload.approach_time == '0)
      else $error("no relative motion with nonzero time");

   a_within_horizon : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.payload.approach_time <= horizon_ff)
      else $error("result beyond time horizon");

   a_empty_after_reset : assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_chan.valid && !nd_valid_ff)
      else $error("pipeline not empty after reset");

   a_full_blocks_input : assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> rsp_chan.valid && !rsp_chan.ready)
      else $error("input stalled while output drains");
`endif

endmodule
